### design/ctc_pkg.sv
// Package for the connection table: sizes, operation and status codes,
// request, response, row and cell control types. No dependencies.

package ctc_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int CNT_W   = 5;

	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_REMOVE = 2'd1;
	localparam logic [1:0] MODE_LOOKUP = 2'd2;
	localparam logic [1:0] MODE_LIST   = 2'd3;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_FULL      = 2'd1;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
	localparam logic [1:0] STAT_EMPTY     = 2'd3;

	typedef struct packed {
		logic [1:0]       mode;
		logic [15:0]      conn_key;
		logic [31:0]      ip_addr;
		logic [15:0]      port_num;
		logic [CNT_W-1:0] list_limit;
	} ctc_req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [31:0]      found_ip;
		logic [15:0]      found_port;
		logic [15:0]      listed_key;
		logic [CNT_W-1:0] entry_count;
		logic             last;
	} ctc_rsp_t;

	typedef struct packed {
		logic [15:0] key;
		logic [31:0] ip;
		logic [15:0] port;
	} ctc_row_t;

	typedef struct packed {
		logic live;
		logic capture;
		logic write;
		logic shift;
		logic load_list;
		logic shift_list;
	} ctc_cell_ctl_t;

endpackage

### design/ctc_cell.sv
// One row cell of the connection table: holds a row, compares its key,
// takes its upper neighbor's row on removal, and shifts list keys down.
// Depends on ctc_pkg.

module ctc_cell
	import ctc_pkg::*;
(
	input  logic          clk,
	input  ctc_cell_ctl_t ctl,
	input  ctc_row_t      wr_data,
	input  ctc_row_t      nbr_row,
	input  logic [15:0]   nbr_list,
	input  logic [15:0]   probe_key,
	output ctc_row_t      row,
	output logic [15:0]   list_key,
	output logic          match
);

	ctc_row_t    row_q;
	logic [15:0] list_q;
	logic        match_s1;

	always_ff @(posedge clk) begin
		if (ctl.write) begin
			row_q <= wr_data;
		end else if (ctl.shift) begin
			row_q <= nbr_row;
		end
		if (ctl.load_list) begin
			list_q <= row_q.key;
		end else if (ctl.shift_list) begin
			list_q <= nbr_list;
		end
		if (ctl.capture) begin
			match_s1 <= ctl.live && (row_q.key == probe_key);
		end
	end

	assign row      = row_q;
	assign list_key = list_q;
	assign match    = match_s1;

endmodule

### design/connection_table_cam.sv
// Connection table top level: control sequencer over a chain of ctc_cell rows.
// Insert, remove and lookup run a key compare, then the first-match act;
// list returns n keys, one key per cycle out of the cell chain.
// A new transaction is taken in the cycle its last result is shown.
// Reset clears the row count and sequencer; row contents stay undefined.
// Results are shown for one cycle with done; the receiver cannot stall.

module connection_table_cam
	import ctc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  ctc_req_t req,
	output logic     done,
	output ctc_rsp_t rsp
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_LIST
	} state_t;

	state_t           state_q;
	ctc_req_t         cmd_q;
	ctc_rsp_t         rsp_q;
	logic             done_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] rem_q;

	ctc_cell_ctl_t    ctl      [ENTRIES];
	ctc_row_t         rows     [ENTRIES];
	ctc_row_t         nbr_rows [ENTRIES];
	logic [15:0]      lkeys    [ENTRIES];
	logic [15:0]      nbr_keys [ENTRIES];
	logic [ENTRIES-1:0] match;

	logic             accept;
	logic             hit;
	logic [IDX_W-1:0] idx;
	logic [CNT_W-1:0] list_n;
	logic             exec;
	ctc_row_t         wr_row;
	ctc_rsp_t         exec_rsp;
	logic [CNT_W-1:0] next_count;
	logic             list_go;
	logic             list_end;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign exec     = (state_q == ST_EXEC);
	assign list_n   = (cmd_q.list_limit < count_q) ? cmd_q.list_limit : count_q;
	assign list_end = (rem_q == CNT_W'(1));
	assign wr_row = '{key: cmd_q.conn_key, ip: cmd_q.ip_addr, port: cmd_q.port_num};

	always_comb begin
		hit = 1'b0;
		idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit = 1'b1;
				idx = IDX_W'(i);
			end
		end
	end

	always_comb begin
		exec_rsp      = '0;
		exec_rsp.last = 1'b1;
		next_count    = count_q;
		list_go       = 1'b0;
		unique case (cmd_q.mode)
			MODE_INSERT: begin
				if (count_q >= CNT_W'(ENTRIES)) begin
					exec_rsp.status = STAT_FULL;
				end else begin
					exec_rsp.status = STAT_OK;
					next_count      = count_q + CNT_W'(1);
				end
			end
			MODE_REMOVE: begin
				if (hit) begin
					exec_rsp.status = STAT_OK;
					next_count      = count_q - CNT_W'(1);
				end else begin
					exec_rsp.status = STAT_NOT_FOUND;
				end
			end
			MODE_LOOKUP: begin
				if (hit) begin
					exec_rsp.status     = STAT_OK;
					exec_rsp.found_ip   = rows[idx].ip;
					exec_rsp.found_port = rows[idx].port;
				end else begin
					exec_rsp.status = STAT_NOT_FOUND;
				end
			end
			default: begin
				if (list_n == '0) begin
					exec_rsp.status = STAT_EMPTY;
				end else begin
					list_go = 1'b1;
				end
			end
		endcase
		exec_rsp.entry_count = next_count;
	end

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		always_comb begin
			ctl[g].live       = CNT_W'(g) < count_q;
			ctl[g].capture    = accept;
			ctl[g].write      = exec && (cmd_q.mode == MODE_INSERT) && (count_q == CNT_W'(g));
			ctl[g].shift      = exec && (cmd_q.mode == MODE_REMOVE) && hit
				&& (IDX_W'(g) >= idx);
			ctl[g].load_list  = exec && (cmd_q.mode == MODE_LIST);
			ctl[g].shift_list = (state_q == ST_LIST);
		end

		if (g == ENTRIES - 1) begin : g_end
			assign nbr_rows[g] = rows[g];
			assign nbr_keys[g] = '0;
		end else begin : g_mid
			assign nbr_rows[g] = rows[g+1];
			assign nbr_keys[g] = lkeys[g+1];
		end

		ctc_cell u_cell (
			.clk       (clk),
			.ctl       (ctl[g]),
			.wr_data   (wr_row),
			.nbr_row   (nbr_rows[g]),
			.nbr_list  (nbr_keys[g]),
			.probe_key (req.conn_key),
			.row       (rows[g]),
			.list_key  (lkeys[g]),
			.match     (match[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cmd_q   <= '0;
			rsp_q   <= '0;
			done_q  <= 1'b0;
			count_q <= '0;
			rem_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					done_q <= 1'b0;
					if (start) begin
						cmd_q   <= req;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					rsp_q   <= exec_rsp;
					done_q  <= !list_go;
					count_q <= next_count;
					rem_q   <= list_n;
					state_q <= list_go ? ST_LIST : ST_IDLE;
				end
				ST_LIST: begin
					rsp_q <= '{status: STAT_OK, found_ip: '0, found_port: '0,
						listed_key: lkeys[0], entry_count: count_q, last: list_end};
					done_q  <= 1'b1;
					rem_q   <= rem_q - CNT_W'(1);
					state_q <= list_end ? ST_IDLE : ST_LIST;
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

### tb/connection_table_cam_test.sv
// Self-checking testbench for the connection table: directed and random
// insert, remove, lookup and list transactions against a shadow table.
// Depends on ctc_pkg and connection_table_cam.

module connection_table_cam_test;
	import ctc_pkg::*;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	ctc_req_t req;
	logic     done;
	ctc_rsp_t rsp;

	logic [15:0] key_tab  [ENTRIES];
	logic [31:0] ip_tab   [ENTRIES];
	logic [15:0] port_tab [ENTRIES];
	int          rows_held;
	ctc_rsp_t    owed_rsp [$];
	bit          failed;

	connection_table_cam DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.done  (done),
		.rsp   (rsp)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic ctc_req_t make_req(logic [1:0] mode, logic [15:0] key,
			logic [31:0] ip, logic [15:0] port, logic [CNT_W-1:0] limit);
		ctc_req_t r;
		r.mode       = mode;
		r.conn_key   = key;
		r.ip_addr    = ip;
		r.port_num   = port;
		r.list_limit = limit;
		return r;
	endfunction

	function automatic void shadow_table_op(ctc_req_t item);
		ctc_rsp_t r;
		int hit;
		int n;
		r = '0;
		r.last = 1'b1;
		hit = -1;
		for (int i = 0; i < rows_held; i++)
			if (hit < 0 && key_tab[i] == item.conn_key)
				hit = i;
		case (item.mode)
			MODE_INSERT: begin
				if (rows_held >= ENTRIES) begin
					r.status = STAT_FULL;
				end else begin
					key_tab[rows_held]  = item.conn_key;
					ip_tab[rows_held]   = item.ip_addr;
					port_tab[rows_held] = item.port_num;
					rows_held++;
					r.status = STAT_OK;
				end
			end
			MODE_REMOVE: begin
				if (hit < 0) begin
					r.status = STAT_NOT_FOUND;
				end else begin
					for (int i = hit; i + 1 < rows_held; i++) begin
						key_tab[i]  = key_tab[i + 1];
						ip_tab[i]   = ip_tab[i + 1];
						port_tab[i] = port_tab[i + 1];
					end
					rows_held--;
					r.status = STAT_OK;
				end
			end
			MODE_LOOKUP: begin
				if (hit < 0) begin
					r.status = STAT_NOT_FOUND;
				end else begin
					r.status     = STAT_OK;
					r.found_ip   = ip_tab[hit];
					r.found_port = port_tab[hit];
				end
			end
			default: begin
				n = (item.list_limit < rows_held) ? int'(item.list_limit) : rows_held;
				if (n > 16)
					n = 16;
				if (n == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					r.status = STAT_OK;
					r.entry_count = CNT_W'(rows_held);
					for (int i = 0; i < n - 1; i++) begin
						r.listed_key = key_tab[i];
						r.last       = 1'b0;
						owed_rsp.push_back(r);
					end
					r.listed_key = key_tab[n - 1];
					r.last       = 1'b1;
				end
			end
		endcase
		r.entry_count = CNT_W'(rows_held);
		owed_rsp.push_back(r);
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			failed = 1'b1;
		end
	endtask

	always @(posedge clk) begin
		ctc_rsp_t want;
		if (arst_n && done) begin
			if (owed_rsp.size() == 0) begin
				$error("unexpected result: %h", rsp);
				failed = 1'b1;
			end else begin
				want = owed_rsp.pop_front();
				check_field("status", want.status, rsp.status);
				check_field("found_ip", want.found_ip, rsp.found_ip);
				check_field("found_port", want.found_port, rsp.found_port);
				check_field("listed_key", want.listed_key, rsp.listed_key);
				check_field("entry_count", want.entry_count, rsp.entry_count);
				check_field("last", want.last, rsp.last);
			end
		end
	end

	task automatic send_op(ctc_req_t item);
		int gap;
		gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 12) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req   <= item;
		@(posedge clk);
		while (busy) @(posedge clk);
		shadow_table_op(item);
	endtask

	task automatic wait_drained;
		start <= 1'b0;
		while (owed_rsp.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic test_empty_table;
		send_op(make_req(MODE_LIST, 16'h0000, 32'h0, 16'h0, 5'd16));
		send_op(make_req(MODE_LOOKUP, 16'h1234, 32'h0, 16'h0, 5'd0));
		send_op(make_req(MODE_REMOVE, 16'hFFFF, 32'h0, 16'h0, 5'd0));
	endtask

	task automatic test_fill_to_full;
		logic [15:0] key;
		logic [31:0] ip;
		logic [15:0] port;
		for (int i = 0; i < ENTRIES; i++) begin
			key  = (i == 0) ? 16'h0000 : (i == ENTRIES - 1) ? 16'hFFFF :
			       (i == 5 || i == 9) ? 16'h1234 : 16'h0100 + 16'(i);
			ip   = (i == 0) ? 32'h0 : (i == ENTRIES - 1) ? 32'hFFFF_FFFF : $urandom;
			port = (i == 0) ? 16'h0 : (i == ENTRIES - 1) ? 16'hFFFF : 16'($urandom);
			send_op(make_req(MODE_INSERT, key, ip, port, 5'd0));
		end
		send_op(make_req(MODE_INSERT, 16'hABCD, 32'h5555_AAAA, 16'hAA55, 5'd0));
	endtask

	task automatic test_duplicate_keys;
		send_op(make_req(MODE_LOOKUP, 16'h1234, 32'h0, 16'h0, 5'd0));
		send_op(make_req(MODE_REMOVE, 16'h1234, 32'h0, 16'h0, 5'd0));
		send_op(make_req(MODE_LOOKUP, 16'h1234, 32'h0, 16'h0, 5'd0));
	endtask

	task automatic test_list_limits;
		send_op(make_req(MODE_LIST, 16'h0, 32'h0, 16'h0, 5'd16));
		send_op(make_req(MODE_LIST, 16'h0, 32'h0, 16'h0, 5'd0));
		send_op(make_req(MODE_LIST, 16'h0, 32'h0, 16'h0, 5'd31));
		send_op(make_req(MODE_REMOVE, 16'hFFFF, 32'h0, 16'h0, 5'd0));
	endtask

	task automatic test_random_traffic(int count, int insert_pct);
		logic [1:0]  mode;
		logic [15:0] key;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 99) < insert_pct)
				mode = MODE_INSERT;
			else
				case ($urandom_range(0, 2))
					0: mode = MODE_REMOVE;
					1: mode = MODE_LOOKUP;
					default: mode = MODE_LIST;
				endcase
			if (rows_held > 0 && $urandom_range(0, 3) != 0)
				key = key_tab[$urandom_range(0, rows_held - 1)];
			else
				key = 16'($urandom);
			send_op(make_req(mode, key, $urandom, 16'($urandom),
				CNT_W'($urandom_range(0, 16))));
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		start     = 1'b0;
		req       = '0;
		rows_held = 0;
		failed    = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_fill_to_full();
		wait_drained();
		test_duplicate_keys();
		test_list_limits();
		wait_drained();
		test_random_traffic(45, 60);
		wait_drained();
		test_random_traffic(40, 20);

		wait_drained();
		repeat (20) @(posedge clk);
		if (!failed && owed_rsp.size() == 0)
			$display("** connection_table_cam: PASSED **");
		else
			$display("** connection_table_cam: FAILED **");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("** connection_table_cam: FAILED **");
		$finish;
	end

endmodule
